FILE: rtl/bqe_pkg.sv
// shared types, codes and constants of the biquad cascade equaliser
package bqe_pkg;

    // default build of the block
    localparam int DEF_MAX_CHANNELS   = 8;
    localparam int DEF_NUM_SECTIONS   = 6;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 30;

    // fixed field and word widths
    localparam int DELAY_BITS        = 40;
    localparam int COEF_BITS         = 32;
    localparam int COEFS_PER_SECTION = 5;
    localparam int OP_BITS           = 2;
    localparam int CHANNEL_BITS      = 3;
    localparam int SECTION_BITS      = 3;
    localparam int COEF_INDEX_BITS   = 3;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 6;
    localparam int CFG_MASK_BITS     = 6;
    localparam int CFG_COUNT_BITS    = 4;

    // item operations
    localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    // coefficient slots within a section
    localparam logic [COEF_INDEX_BITS-1:0] CI_B0 = 3'd0;
    localparam logic [COEF_INDEX_BITS-1:0] CI_B1 = 3'd1;
    localparam logic [COEF_INDEX_BITS-1:0] CI_B2 = 3'd2;
    localparam logic [COEF_INDEX_BITS-1:0] CI_A1 = 3'd3;
    localparam logic [COEF_INDEX_BITS-1:0] CI_A2 = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EQ_ON = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    // steps through one section
    typedef enum logic [2:0] {
        SP_FETCH,
        SP_MUL_B0,
        SP_MUL_B1,
        SP_MUL_B2,
        SP_MUL_A1,
        SP_MUL_A2,
        SP_NEW_Z1,
        SP_NEW_Z2
    } step_t;

    // accumulator operations of the arithmetic unit
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_Y,
        ACC_Z1_PRE,
        ACC_Z2_PRE,
        ACC_Z1_NEW,
        ACC_Z2_NEW
    } acc_op_t;

    // control from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    mul_y;
        logic    ld_delay;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

FILE: rtl/bqe_ram.sv
// generic single write port ram with registered read
module bqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bqe_mac.sv
// shared multiplier, rounding stage and saturating accumulator of the section arithmetic
module bqe_mac #(
    parameter int SAMPLE_BITS    = bqe_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = bqe_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                clk,
    input  bqe_pkg::mac_ctrl_t                  ctrl,
    input  logic [bqe_pkg::COEF_BITS-1:0]       coef,
    input  logic signed [SAMPLE_BITS-1:0]       x,
    input  logic [2*bqe_pkg::DELAY_BITS-1:0]    dly_q,
    input  logic                                dly_valid,
    output logic signed [SAMPLE_BITS-1:0]       y,
    output logic [2*bqe_pkg::DELAY_BITS-1:0]    z_new
);

    import bqe_pkg::*;

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int RND_W  = PROD_W - COEF_FRAC_BITS;
    localparam int ACC_W  = ((DELAY_BITS > RND_W) ? DELAY_BITS : RND_W) + 2;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);

    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] D_MAX =
        {{(ACC_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN =
        {{(ACC_W-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] mul_op;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [PROD_W-1:0]             round_sum;
    logic signed [RND_W-1:0]       rnd_next;
    logic signed [RND_W-1:0]       rnd_reg;
    logic signed [DELAY_BITS-1:0]  z1_reg;
    logic signed [DELAY_BITS-1:0]  z2_reg;
    logic signed [DELAY_BITS-1:0]  z1n_reg;
    logic signed [DELAY_BITS-1:0]  sat_d;
    logic signed [ACC_W-1:0]       acc1_reg;
    logic signed [ACC_W-1:0]       acc2_reg;
    logic signed [ACC_W-1:0]       add_a;
    logic signed [ACC_W-1:0]       add_b;
    logic signed [ACC_W-1:0]       sum;
    logic                          sub;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [SAMPLE_BITS-1:0] sat_s;

    // multiplier operand: section input or section output
    assign mul_op    = ctrl.mul_y ? y_reg : x;
    assign prod_next = $signed(coef) * mul_op;

    // round half up, then drop the fraction bits
    assign round_sum = prod_reg + HALF;
    assign rnd_next  = round_sum[PROD_W-1:COEF_FRAC_BITS];

    // shared adder, operand chosen by the accumulator operation
    always_comb
    begin
        add_b = {{(ACC_W-RND_W){rnd_reg[RND_W-1]}}, rnd_reg};
        sub   = (ctrl.acc_op == ACC_Z1_NEW) || (ctrl.acc_op == ACC_Z2_NEW);
        unique case (ctrl.acc_op)
            ACC_Y:      add_a = {{(ACC_W-DELAY_BITS){z1_reg[DELAY_BITS-1]}}, z1_reg};
            ACC_Z1_PRE: add_a = {{(ACC_W-DELAY_BITS){z2_reg[DELAY_BITS-1]}}, z2_reg};
            ACC_Z1_NEW: add_a = acc1_reg;
            ACC_Z2_NEW: add_a = acc2_reg;
            default:    add_a = '0;
        endcase
        sum = add_a + (sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, sub};
    end

    // saturation to the sample and delay ranges
    always_comb
    begin
        priority if (sum > S_MAX)
            sat_s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (sum < S_MIN)
            sat_s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_s = sum[SAMPLE_BITS-1:0];

        priority if (sum > D_MAX)
            sat_d = {1'b0, {(DELAY_BITS-1){1'b1}}};
        else if (sum < D_MIN)
            sat_d = {1'b1, {(DELAY_BITS-1){1'b0}}};
        else
            sat_d = sum[DELAY_BITS-1:0];
    end

    // product, rounding and accumulator registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rnd_reg  <= rnd_next;
        if (ctrl.ld_delay)
        begin
            z1_reg <= dly_valid ? dly_q[2*DELAY_BITS-1:DELAY_BITS] : '0;
            z2_reg <= dly_valid ? dly_q[DELAY_BITS-1:0] : '0;
        end
        unique case (ctrl.acc_op)
            ACC_Y:      y_reg    <= sat_s;
            ACC_Z1_PRE: acc1_reg <= sum;
            ACC_Z2_PRE: acc2_reg <= sum;
            ACC_Z1_NEW: z1n_reg  <= sat_d;
            default:    ;
        endcase
    end

    assign y     = y_reg;
    assign z_new = {z1n_reg, sat_d};

endmodule

FILE: rtl/biquad_cascade_equalizer.sv
// multichannel biquad cascade equaliser, top level with item sequencer
//
// Each sample beat runs through the enabled second-order sections in order, in
// transposed direct form II, on one shared 32 x SAMPLE_BITS multiplier and one
// saturating accumulator. Within a section the five products follow one another
// through the product and rounding registers, and the feedback products wait on
// the section output. Coefficient writes and clear beats give no result. The
// input is stalled while a sample is in flight; a finished result waits in the
// output register while the next beat is accepted. Coefficients and delay words
// live in RAMs; delay words carry a valid bit each, so reset, clear beats and
// section enable edges zero them at once with no clearing pass.
// Coefficients must be written before the sections that use them are enabled.
module biquad_cascade_equalizer #(
    parameter int MAX_CHANNELS   = bqe_pkg::DEF_MAX_CHANNELS,
    parameter int NUM_SECTIONS   = bqe_pkg::DEF_NUM_SECTIONS,
    parameter int SAMPLE_BITS    = bqe_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = bqe_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [bqe_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bqe_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bqe_pkg::OP_BITS-1:0]           operation,
    input  logic [bqe_pkg::CHANNEL_BITS-1:0]      channel,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    input  logic [bqe_pkg::SECTION_BITS-1:0]      section,
    input  logic [bqe_pkg::COEF_INDEX_BITS-1:0]   coef_index,
    input  logic signed [bqe_pkg::COEF_BITS-1:0]  coef_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    output logic [bqe_pkg::CHANNEL_BITS-1:0]      channel_out
);

    import bqe_pkg::*;

    localparam int NUM_DLY  = NUM_SECTIONS * MAX_CHANNELS;
    localparam int NUM_COEF = NUM_SECTIONS * COEFS_PER_SECTION;
    localparam int DADDR_W  = $clog2(NUM_DLY);
    localparam int CADDR_W  = $clog2(NUM_COEF);
    localparam int SEC_W    = $clog2(NUM_SECTIONS);

    state_t                        state_reg, state_next;
    step_t                         step_reg, step_next;
    logic [SEC_W-1:0]              sec_reg, sec_next;
    logic [CHANNEL_BITS-1:0]       ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          eq_on_reg, eq_on_next;
    logic [CFG_MASK_BITS-1:0]      mask_reg, mask_next;
    logic [CFG_COUNT_BITS-1:0]     count_reg, count_next;
    logic [NUM_SECTIONS-1:0]       applied_reg, applied_next;
    logic [NUM_DLY-1:0]            valid_reg, valid_next;
    logic                          dly_valid_reg, dly_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, sample_out_next;
    logic [CHANNEL_BITS-1:0]       channel_out_reg, channel_out_next;

    logic                          in_accept;
    logic [NUM_SECTIONS-1:0]       mask_ns;
    logic [NUM_SECTIONS-1:0]       rising;
    logic                          ch_ok;
    logic [SEC_W-1:0]              first_sec;
    logic [SEC_W-1:0]              next_sec;
    logic                          next_found;
    logic [COEF_INDEX_BITS-1:0]    coef_sel;
    logic                          coef_addr_ok;
    logic                          coef_we;
    logic [CADDR_W-1:0]            coef_waddr;
    logic [CADDR_W-1:0]            coef_raddr;
    logic [COEF_BITS-1:0]          coef_q;
    logic                          dly_we;
    logic [DADDR_W-1:0]            dly_addr;
    logic [2*DELAY_BITS-1:0]       dly_q;
    logic [2*DELAY_BITS-1:0]       z_new;
    logic signed [SAMPLE_BITS-1:0] y;
    mac_ctrl_t                     ctrl;

    // input handshake
    assign in_stall  = !rst_n || (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // section mask and channel range
    assign mask_ns = NUM_SECTIONS'(mask_reg);
    assign rising  = mask_ns & ~applied_reg;
    assign ch_ok   = (32'(channel) < MAX_CHANNELS) && ({1'b0, channel} < count_reg);

    // ram addresses
    assign coef_addr_ok = (32'(section) < NUM_SECTIONS) &&
                          (32'(coef_index) < COEFS_PER_SECTION);
    assign coef_waddr = CADDR_W'(32'(section) * COEFS_PER_SECTION + 32'(coef_index));
    assign coef_raddr = CADDR_W'(32'(sec_reg) * COEFS_PER_SECTION + 32'(coef_sel));
    assign dly_addr   = DADDR_W'(32'(sec_reg) * MAX_CHANNELS + 32'(ch_reg));

    // lowest enabled section of the new mask
    always_comb
    begin
        first_sec = '0;
        for (int i = NUM_SECTIONS - 1; i >= 0; i--)
        begin
            if (mask_ns[i])
            begin
                first_sec = SEC_W'(i);
            end
        end
    end

    // next enabled section after the current one
    always_comb
    begin
        next_found = 1'b0;
        next_sec   = '0;
        for (int i = NUM_SECTIONS - 1; i >= 0; i--)
        begin
            if (applied_reg[i] && (i > int'(sec_reg)))
            begin
                next_found = 1'b1;
                next_sec   = SEC_W'(i);
            end
        end
    end

    // sequencer: next state, ram strobes and arithmetic control
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        sec_next         = sec_reg;
        ch_next          = ch_reg;
        x_next           = x_reg;
        eq_on_next       = eq_on_reg;
        mask_next        = mask_reg;
        count_next       = count_reg;
        applied_next     = applied_reg;
        valid_next       = valid_reg;
        dly_valid_next   = dly_valid_reg;
        out_valid_next   = out_valid_reg;
        sample_out_next  = sample_out_reg;
        channel_out_next = channel_out_reg;
        coef_we          = 1'b0;
        dly_we           = 1'b0;
        coef_sel         = CI_B0;
        ctrl             = '{mul_y: 1'b0, ld_delay: 1'b0, acc_op: ACC_NONE};

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EQ_ON: eq_on_next = cfg_data[0];
                CFG_MASK:  mask_next  = cfg_data[CFG_MASK_BITS-1:0];
                CFG_COUNT: count_next = cfg_data[CFG_COUNT_BITS-1:0];
                default:   ;
            endcase
        end

        // result beat taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (operation)
                        OP_COEF:
                        begin
                            coef_we = coef_addr_ok;
                        end
                        OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        OP_SAMPLE:
                        begin
                            x_next     = sample_in;
                            ch_next    = channel;
                            state_next = ST_OUT;
                            if (count_reg != '0)
                            begin
                                applied_next = mask_ns;
                                // sections switched on start from zeroed delays
                                for (int s = 0; s < NUM_SECTIONS; s++)
                                begin
                                    if (rising[s])
                                    begin
                                        for (int c = 0; c < MAX_CHANNELS; c++)
                                        begin
                                            valid_next[s * MAX_CHANNELS + c] = 1'b0;
                                        end
                                    end
                                end
                                if (eq_on_reg && (mask_ns != '0) && ch_ok)
                                begin
                                    state_next = ST_RUN;
                                    sec_next   = first_sec;
                                    step_next  = SP_FETCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_RUN:
            begin
                unique case (step_reg)
                    SP_FETCH:
                    begin
                        coef_sel       = CI_B0;
                        dly_valid_next = valid_reg[dly_addr];
                        step_next      = SP_MUL_B0;
                    end
                    SP_MUL_B0:
                    begin
                        coef_sel      = CI_B1;
                        ctrl.ld_delay = 1'b1;
                        step_next     = SP_MUL_B1;
                    end
                    SP_MUL_B1:
                    begin
                        coef_sel  = CI_B2;
                        step_next = SP_MUL_B2;
                    end
                    SP_MUL_B2:
                    begin
                        coef_sel    = CI_A1;
                        ctrl.acc_op = ACC_Y;
                        step_next   = SP_MUL_A1;
                    end
                    SP_MUL_A1:
                    begin
                        coef_sel    = CI_A2;
                        ctrl.mul_y  = 1'b1;
                        ctrl.acc_op = ACC_Z1_PRE;
                        step_next   = SP_MUL_A2;
                    end
                    SP_MUL_A2:
                    begin
                        ctrl.mul_y  = 1'b1;
                        ctrl.acc_op = ACC_Z2_PRE;
                        step_next   = SP_NEW_Z1;
                    end
                    SP_NEW_Z1:
                    begin
                        ctrl.acc_op = ACC_Z1_NEW;
                        step_next   = SP_NEW_Z2;
                    end
                    SP_NEW_Z2:
                    begin
                        ctrl.acc_op          = ACC_Z2_NEW;
                        dly_we               = 1'b1;
                        valid_next[dly_addr] = 1'b1;
                        x_next               = y;
                        step_next            = SP_FETCH;
                        if (next_found)
                        begin
                            sec_next = next_sec;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                endcase
            end

            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    sample_out_next  = x_reg;
                    channel_out_next = ch_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= SP_FETCH;
            eq_on_reg     <= 1'b0;
            mask_reg      <= '0;
            count_reg     <= '0;
            applied_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            eq_on_reg     <= eq_on_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            applied_reg   <= applied_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sec_reg         <= sec_next;
        ch_reg          <= ch_next;
        x_reg           <= x_next;
        dly_valid_reg   <= dly_valid_next;
        sample_out_reg  <= sample_out_next;
        channel_out_reg <= channel_out_next;
    end

    // coefficient store
    bqe_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (NUM_COEF)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (coef_raddr),
        .rdata (coef_q)
    );

    // delay store, both words of a section and channel side by side
    bqe_ram #(
        .WIDTH (2 * DELAY_BITS),
        .DEPTH (NUM_DLY)
    ) u_dly_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_addr),
        .wdata (z_new),
        .raddr (dly_addr),
        .rdata (dly_q)
    );

    // shared section arithmetic
    bqe_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .ctrl      (ctrl),
        .coef      (coef_q),
        .x         (x_reg),
        .dly_q     (dly_q),
        .dly_valid (dly_valid_reg),
        .y         (y),
        .z_new     (z_new)
    );

    // result ports
    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = channel_out_reg;

endmodule
